>>> src/coprocessor_alu_instruction_execute_macros.svh
// Assertion helpers shared by the RTL. Both sample on clk and are off during reset.
`ifndef COPROCESSOR_ALU_INSTRUCTION_EXECUTE_MACROS_SVH
`define COPROCESSOR_ALU_INSTRUCTION_EXECUTE_MACROS_SVH

// same-cycle implication
`define CAE_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define CAE_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

>>> src/cae_pkg.sv
`timescale 1ns / 1ps
package cae_pkg;

    localparam int NUM_REGS_DEF = 16;

    // flag bit positions
    localparam int F_Z    = 0;
    localparam int F_CY   = 1;
    localparam int F_S    = 2;
    localparam int F_OV   = 3;
    localparam int F_B    = 4;
    localparam int F_ALT1 = 5;
    localparam int F_ALT2 = 6;

    // opcode groups (high nibble)
    localparam logic [3:0] GRP_MISC  = 4'h0;
    localparam logic [3:0] GRP_TO    = 4'h1;
    localparam logic [3:0] GRP_WITH  = 4'h2;
    localparam logic [3:0] GRP_3     = 4'h3;
    localparam logic [3:0] GRP_4     = 4'h4;
    localparam logic [3:0] GRP_ADD   = 4'h5;
    localparam logic [3:0] GRP_SUB   = 4'h6;
    localparam logic [3:0] GRP_AND   = 4'h7;
    localparam logic [3:0] GRP_MULT  = 4'h8;
    localparam logic [3:0] GRP_9     = 4'h9;
    localparam logic [3:0] GRP_IBT   = 4'hA;
    localparam logic [3:0] GRP_FROM  = 4'hB;
    localparam logic [3:0] GRP_OR    = 4'hC;
    localparam logic [3:0] GRP_INC   = 4'hD;
    localparam logic [3:0] GRP_DEC   = 4'hE;
    localparam logic [3:0] GRP_IWT   = 4'hF;

    // individual opcodes
    localparam logic [7:0] OP_STOP  = 8'h00;
    localparam logic [7:0] OP_CACHE = 8'h02;
    localparam logic [7:0] OP_LSR   = 8'h03;
    localparam logic [7:0] OP_ROL   = 8'h04;
    localparam logic [7:0] OP_BRA   = 8'h05;
    localparam logic [7:0] OP_BGE   = 8'h06;
    localparam logic [7:0] OP_BLT   = 8'h07;
    localparam logic [7:0] OP_BNE   = 8'h08;
    localparam logic [7:0] OP_BEQ   = 8'h09;
    localparam logic [7:0] OP_BPL   = 8'h0A;
    localparam logic [7:0] OP_BMI   = 8'h0B;
    localparam logic [7:0] OP_BCC   = 8'h0C;
    localparam logic [7:0] OP_BCS   = 8'h0D;
    localparam logic [7:0] OP_BVC   = 8'h0E;
    localparam logic [7:0] OP_LOOP  = 8'h3C;
    localparam logic [7:0] OP_ALT1  = 8'h3D;
    localparam logic [7:0] OP_ALT2  = 8'h3E;
    localparam logic [7:0] OP_SWAP  = 8'h4D;
    localparam logic [7:0] OP_COLOR = 8'h4E;
    localparam logic [7:0] OP_NOT   = 8'h4F;
    localparam logic [7:0] OP_MERGE = 8'h70;
    localparam logic [7:0] OP_LINK1 = 8'h91;
    localparam logic [7:0] OP_LINK4 = 8'h94;
    localparam logic [7:0] OP_SEX   = 8'h95;
    localparam logic [7:0] OP_ASR   = 8'h96;
    localparam logic [7:0] OP_ROR   = 8'h97;
    localparam logic [7:0] OP_JMP0  = 8'h98;
    localparam logic [7:0] OP_JMP5  = 8'h9D;
    localparam logic [7:0] OP_LOB   = 8'h9E;
    localparam logic [7:0] OP_FMULT = 8'h9F;
    localparam logic [7:0] OP_HIB   = 8'hC0;

    localparam logic [15:0] MERGE_OV_MASK = 16'hC0C0;
    localparam logic [15:0] MERGE_S_MASK  = 16'h8080;
    localparam logic [15:0] MERGE_CY_MASK = 16'hE0E0;
    localparam logic [15:0] MERGE_Z_MASK  = 16'hF0F0;
    localparam logic [15:0] CACHE_MASK    = 16'hFFF0;
    localparam logic [6:0]  BANK_MASK     = 7'h7F;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] imm_lo;
        logic [7:0] imm_hi;
    } in_beat_t;

    typedef struct packed {
        logic        dest_written;
        logic [3:0]  dest_index;
        logic [15:0] dest_value;
        logic [6:0]  status_flags;
        logic [15:0] next_pc;
        logic [1:0]  imm_used;
        logic        stopped;
        logic        irq_raised;
        logic        cache_flush;
        logic [6:0]  program_bank;
    } out_beat_t;

    typedef struct packed {
        logic [3:0]  ssel;
        logic [3:0]  dsel;
        logic [6:0]  flags;
        logic        irq_pending;
        logic [6:0]  bank;
        logic [15:0] cache_base;
        logic [7:0]  colour;
        logic [7:0]  plot;
    } ctl_t;

endpackage

>>> src/coprocessor_alu_instruction_execute.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake         | Beat
// in      | input     | in_valid/in_stall | in_beat_t: opcode, imm_lo, imm_hi
// out     | output    | out_valid/out_stall | out_beat_t: one result per instruction
// cfg     | input     | cfg_write_en      | cfg_write_data: irq_disable
//
// One instruction per cycle sustained while the output is not stalled.
// A beat sits in the input register, executes in one pass against the register
// file and control state, and lands in the result register at the same edge the
// state is updated, so the next beat sees it immediately.
// Reset clears the register file, all control state and both valid bits.
// A stalled result holds; an occupied input register then holds too and in_stall rises.
module coprocessor_alu_instruction_execute
    import cae_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data,
    input  logic      cfg_write_en,
    input  logic      cfg_write_data
);

`include "coprocessor_alu_instruction_execute_macros.svh"

    logic        s1_valid_reg, s1_valid_next;
    in_beat_t    s1_data_reg;
    logic        out_valid_reg, out_valid_next;
    out_beat_t   out_data_reg;
    logic        irq_disable_reg;
    logic [15:0] rf_reg [NUM_REGS];
    logic [15:0] rf_next [NUM_REGS];
    ctl_t        ctl_reg, ctl_next;
    out_beat_t   res;
    logic        adv, fire, accept;

    // result register frees up when empty or being taken this cycle
    assign adv      = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && adv;
    assign in_stall = s1_valid_reg && !adv;
    assign accept   = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    cae_exec #(
        .NUM_REGS (NUM_REGS)
    ) u_exec (
        .cmd         (s1_data_reg),
        .irq_disable (irq_disable_reg),
        .rf_in       (rf_reg),
        .ctl_in      (ctl_reg),
        .rf_out      (rf_next),
        .ctl_out     (ctl_next),
        .res         (res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            irq_disable_reg <= 1'b0;
            ctl_reg         <= '0;
            for (int i = 0; i < NUM_REGS; i++)
                rf_reg[i] <= 16'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
                irq_disable_reg <= cfg_write_data;
            if (fire)
            begin
                ctl_reg <= ctl_next;
                rf_reg  <= rf_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_data_reg <= in_data;
        if (fire)
            out_data_reg <= res;
    end

    `CAE_ASSERT_NOW(a_stall_holds_item, in_stall, s1_valid_reg)
    `CAE_ASSERT_NOW(a_quiet_dest, out_valid_reg && !out_data_reg.dest_written,
        out_data_reg.dest_index == 4'd0 && out_data_reg.dest_value == 16'd0)
    `CAE_ASSERT_NOW(a_irq_needs_stop, out_valid_reg && out_data_reg.irq_raised,
        out_data_reg.stopped)
    `CAE_ASSERT_NEXT(a_pc_tracks, fire, rf_reg[15] == out_data_reg.next_pc)

endmodule

>>> src/cae_exec.sv
`timescale 1ns / 1ps
module cae_exec
    import cae_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
)
(
    input  in_beat_t    cmd,
    input  logic        irq_disable,
    input  logic [15:0] rf_in  [NUM_REGS],
    input  ctl_t        ctl_in,
    output logic [15:0] rf_out [NUM_REGS],
    output ctl_t        ctl_out,
    output out_beat_t   res
);

    logic [15:0] rf [NUM_REGS];
    ctl_t        c;
    logic [3:0]  n;
    logic [3:0]  grp;
    logic [15:0] sv, nv, rn, pc1, v, pc_val, r4_val;
    logic [16:0] sum;
    logic [31:0] prod;
    logic        alt1, alt2, bf, cyf, cond, sx, reset_pf;
    logic        wr, pc_set, r4_set, touched, set_sz, stp, irq, flush;
    logic [3:0]  widx;
    logic [1:0]  used;

    always_comb
    begin
        rf       = rf_in;
        c        = ctl_in;
        n        = cmd.opcode[3:0];
        grp      = cmd.opcode[7:4];
        alt1     = ctl_in.flags[F_ALT1];
        alt2     = ctl_in.flags[F_ALT2];
        bf       = ctl_in.flags[F_B];
        cyf      = ctl_in.flags[F_CY];
        sv       = rf_in[ctl_in.ssel];
        rn       = rf_in[n];
        nv       = alt2 ? {12'd0, n} : rn;
        sum      = 17'd0;
        prod     = 32'd0;
        v        = 16'd0;
        pc_val   = 16'd0;
        r4_val   = 16'd0;
        wr       = 1'b0;
        widx     = 4'd0;
        set_sz   = 1'b0;
        pc_set   = 1'b0;
        r4_set   = 1'b0;
        stp      = 1'b0;
        irq      = 1'b0;
        flush    = 1'b0;
        reset_pf = 1'b1;
        cond     = 1'b0;
        sx       = ctl_in.flags[F_S] ^ ctl_in.flags[F_OV];

        // immediate bytes advance the pc before anything else looks at it
        if (grp == GRP_IWT)
            used = 2'd2;
        else if (grp == GRP_IBT || (grp == GRP_MISC && cmd.opcode >= OP_BRA))
            used = 2'd1;
        else
            used = 2'd0;
        pc1 = rf_in[15] + {14'd0, used};
        rf[15] = pc1;

        unique case (grp)
            GRP_MISC:
            begin
                if (cmd.opcode == OP_STOP)
                begin
                    stp = 1'b1;
                    if (!irq_disable)
                    begin
                        irq = 1'b1;
                        c.irq_pending = 1'b1;
                    end
                end
                else if (cmd.opcode == OP_CACHE)
                begin
                    if (c.cache_base != (pc1 & CACHE_MASK))
                    begin
                        c.cache_base = pc1 & CACHE_MASK;
                        flush = 1'b1;
                    end
                end
                else if (cmd.opcode == OP_LSR)
                begin
                    c.flags[F_CY] = sv[0];
                    wr = 1'b1; widx = c.dsel; v = {1'b0, sv[15:1]}; set_sz = 1'b1;
                end
                else if (cmd.opcode == OP_ROL)
                begin
                    c.flags[F_CY] = sv[15];
                    wr = 1'b1; widx = c.dsel; v = {sv[14:0], cyf}; set_sz = 1'b1;
                end
                else if (cmd.opcode >= OP_BRA)
                begin
                    unique case (cmd.opcode)
                        OP_BRA:  cond = 1'b1;
                        OP_BGE:  cond = !sx;
                        OP_BLT:  cond = sx;
                        OP_BNE:  cond = !ctl_in.flags[F_Z];
                        OP_BEQ:  cond = ctl_in.flags[F_Z];
                        OP_BPL:  cond = !ctl_in.flags[F_S];
                        OP_BMI:  cond = ctl_in.flags[F_S];
                        OP_BCC:  cond = !cyf;
                        OP_BCS:  cond = cyf;
                        OP_BVC:  cond = !ctl_in.flags[F_OV];
                        default: cond = ctl_in.flags[F_OV];
                    endcase
                    if (cond)
                    begin
                        pc_set = 1'b1;
                        pc_val = pc1 + {{8{cmd.imm_lo[7]}}, cmd.imm_lo};
                    end
                    reset_pf = 1'b0;
                end
            end
            GRP_TO:
            begin
                if (bf)
                begin
                    wr = 1'b1; widx = n; v = sv;
                end
                else
                begin
                    c.dsel = n;
                    reset_pf = 1'b0;
                end
            end
            GRP_WITH:
            begin
                c.ssel = n;
                c.dsel = n;
                c.flags[F_B] = 1'b1;
                reset_pf = 1'b0;
            end
            GRP_3:
            begin
                if (cmd.opcode == OP_LOOP)
                begin
                    v = rf_in[12] - 16'd1;
                    wr = 1'b1; widx = 4'd12; set_sz = 1'b1;
                    if (v != 16'd0)
                    begin
                        pc_set = 1'b1;
                        pc_val = rf_in[13];
                    end
                end
                else if (cmd.opcode >= OP_ALT1)
                begin
                    c.flags[F_B] = 1'b0;
                    if (cmd.opcode != OP_ALT2) c.flags[F_ALT1] = 1'b1;
                    if (cmd.opcode != OP_ALT1) c.flags[F_ALT2] = 1'b1;
                    reset_pf = 1'b0;
                end
            end
            GRP_4:
            begin
                if (cmd.opcode == OP_SWAP)
                begin
                    wr = 1'b1; widx = c.dsel; v = {sv[7:0], sv[15:8]}; set_sz = 1'b1;
                end
                else if (cmd.opcode == OP_COLOR)
                begin
                    if (alt1)
                        c.plot = sv[7:0];
                    else if (ctl_in.plot[2])
                        c.colour = {ctl_in.colour[7:4], sv[7:4]};
                    else if (ctl_in.plot[3])
                        c.colour = {ctl_in.colour[7:4], sv[3:0]};
                    else
                        c.colour = sv[7:0];
                end
                else if (cmd.opcode == OP_NOT)
                begin
                    wr = 1'b1; widx = c.dsel; v = ~sv; set_sz = 1'b1;
                end
            end
            GRP_ADD:
            begin
                sum = {1'b0, sv} + {1'b0, nv} + {16'd0, alt1 & cyf};
                c.flags[F_OV] = ~(sv[15] ^ nv[15]) & (nv[15] ^ sum[15]);
                c.flags[F_CY] = sum[16];
                wr = 1'b1; widx = c.dsel; v = sum[15:0]; set_sz = 1'b1;
            end
            GRP_SUB:
            begin
                nv  = (!alt2 || alt1) ? rn : {12'd0, n};
                sum = {1'b0, sv} - {1'b0, nv} - {16'd0, !alt2 & alt1 & !cyf};
                v   = sum[15:0];
                c.flags[F_OV] = (sv[15] ^ nv[15]) & (sv[15] ^ v[15]);
                c.flags[F_S]  = v[15];
                c.flags[F_CY] = !sum[16];
                c.flags[F_Z]  = (v == 16'd0);
                if (!alt2 || !alt1)
                begin
                    wr = 1'b1; widx = c.dsel;
                end
            end
            GRP_AND:
            begin
                wr = 1'b1; widx = c.dsel;
                if (cmd.opcode == OP_MERGE)
                begin
                    v = {rf_in[7][15:8], rf_in[8][15:8]};
                    c.flags[F_OV] = (v & MERGE_OV_MASK) != 16'd0;
                    c.flags[F_S]  = (v & MERGE_S_MASK) != 16'd0;
                    c.flags[F_CY] = (v & MERGE_CY_MASK) != 16'd0;
                    c.flags[F_Z]  = (v & MERGE_Z_MASK) != 16'd0;
                end
                else
                begin
                    v = sv & (alt1 ? ~nv : nv);
                    set_sz = 1'b1;
                end
            end
            GRP_MULT:
            begin
                if (alt1)
                    v = {8'd0, sv[7:0]} * {8'd0, nv[7:0]};
                else
                    v = 16'($signed(sv[7:0]) * $signed(nv[7:0]));
                wr = 1'b1; widx = c.dsel; set_sz = 1'b1;
            end
            GRP_9:
            begin
                if (cmd.opcode >= OP_LINK1 && cmd.opcode <= OP_LINK4)
                begin
                    wr = 1'b1; widx = 4'd11; v = pc1 + {12'd0, n};
                end
                else if (cmd.opcode == OP_SEX)
                begin
                    wr = 1'b1; widx = c.dsel; v = {{8{sv[7]}}, sv[7:0]}; set_sz = 1'b1;
                end
                else if (cmd.opcode == OP_ASR)
                begin
                    c.flags[F_CY] = sv[0];
                    // div2 form: all ones rounds to zero
                    v = (alt1 && sv == 16'hFFFF) ? 16'd0 : {sv[15], sv[15:1]};
                    wr = 1'b1; widx = c.dsel; set_sz = 1'b1;
                end
                else if (cmd.opcode == OP_ROR)
                begin
                    c.flags[F_CY] = sv[0];
                    wr = 1'b1; widx = c.dsel; v = {cyf, sv[15:1]}; set_sz = 1'b1;
                end
                else if (cmd.opcode >= OP_JMP0 && cmd.opcode <= OP_JMP5)
                begin
                    pc_set = 1'b1;
                    if (!alt1)
                        pc_val = rf[n];
                    else
                    begin
                        c.bank       = rf[n][6:0] & BANK_MASK;
                        pc_val       = sv;
                        c.cache_base = sv & CACHE_MASK;
                        flush        = 1'b1;
                    end
                end
                else if (cmd.opcode == OP_LOB)
                begin
                    v = {8'd0, sv[7:0]};
                    wr = 1'b1; widx = c.dsel;
                    c.flags[F_S] = v[7];
                    c.flags[F_Z] = (v == 16'd0);
                end
                else if (cmd.opcode == OP_FMULT)
                begin
                    prod = 32'($signed(sv) * $signed(rf_in[6]));
                    if (alt1)
                    begin
                        r4_set = 1'b1;
                        r4_val = prod[15:0];
                    end
                    wr = 1'b1; widx = c.dsel; v = prod[31:16]; set_sz = 1'b1;
                    c.flags[F_CY] = prod[15];
                end
            end
            GRP_IBT:
            begin
                if (!alt1 && !alt2)
                begin
                    wr = 1'b1; widx = n; v = {{8{cmd.imm_lo[7]}}, cmd.imm_lo};
                end
            end
            GRP_FROM:
            begin
                if (bf)
                begin
                    wr = 1'b1; widx = c.dsel; v = rn; set_sz = 1'b1;
                    c.flags[F_OV] = rn[7];
                end
                else
                begin
                    c.ssel = n;
                    reset_pf = 1'b0;
                end
            end
            GRP_OR:
            begin
                wr = 1'b1; widx = c.dsel;
                if (cmd.opcode == OP_HIB)
                begin
                    v = {8'd0, sv[15:8]};
                    c.flags[F_S] = v[7];
                    c.flags[F_Z] = (v == 16'd0);
                end
                else
                begin
                    v = alt1 ? (sv ^ nv) : (sv | nv);
                    set_sz = 1'b1;
                end
            end
            GRP_INC, GRP_DEC:
            begin
                if (n != 4'hF)
                begin
                    v = (grp == GRP_INC) ? rn + 16'd1 : rn - 16'd1;
                    wr = 1'b1; widx = n;
                    c.flags[F_S] = v[15];
                    c.flags[F_Z] = (v == 16'd0);
                end
            end
            GRP_IWT:
            begin
                if (!alt1 && !alt2)
                begin
                    wr = 1'b1; widx = n; v = {cmd.imm_hi, cmd.imm_lo};
                end
            end
            default:
            begin
            end
        endcase

        if (set_sz)
        begin
            c.flags[F_S] = v[15];
            c.flags[F_Z] = (v == 16'd0);
        end

        // write order: fmult low half, pc, then the reported destination
        if (r4_set) rf[4] = r4_val;
        if (pc_set) rf[15] = pc_val;
        if (wr) rf[widx] = v;
        touched = pc_set || (wr && widx == 4'd15);

        if (reset_pf)
        begin
            c.flags[F_B]    = 1'b0;
            c.flags[F_ALT1] = 1'b0;
            c.flags[F_ALT2] = 1'b0;
            c.ssel = 4'd0;
            c.dsel = 4'd0;
        end
        if (!touched) rf[15] = rf[15] + 16'd1;

        rf_out  = rf;
        ctl_out = c;

        res.dest_written = wr;
        res.dest_index   = wr ? widx : 4'd0;
        res.dest_value   = wr ? v : 16'd0;
        res.status_flags = c.flags;
        res.next_pc      = rf[15];
        res.imm_used     = used;
        res.stopped      = stp;
        res.irq_raised   = irq;
        res.cache_flush  = flush;
        res.program_bank = c.bank;
    end

endmodule
